>>> rtl/core/mft_pkg.sv
package mft_pkg;

    // Word format of the node values
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DEPTH_W   = WORD_BITS - 1;

    // Configuration register formats
    localparam int GRAV_W  = 24;
    localparam int ROUGH_W = 16;
    localparam int GR_FRAC = 48;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;

    localparam logic [GRAV_W-1:0]  GRAVITY_RST   = 24'd642253;
    localparam logic [ROUGH_W-1:0] ROUGHNESS_RST = 16'd1311;

    // Register index, taken from the word address
    localparam logic [0:0] REG_GRAVITY   = 1'b0;
    localparam logic [0:0] REG_ROUGHNESS = 1'b1;

    // Datapath widths
    localparam int GN_W    = GRAV_W + ROUGH_W;
    localparam int GNN_W   = GN_W + ROUGH_W;
    localparam int K_W     = GNN_W - (GR_FRAC - FRAC_BITS);
    localparam int SQ_W    = 2 * WORD_BITS;
    localparam int MAG_W   = WORD_BITS;
    localparam int HS_W    = DEPTH_W + 2 * FRAC_BITS;
    localparam int CBRT_W  = (HS_W + 2) / 3;
    localparam int HH_W    = 2 * DEPTH_W;
    localparam int HH_LO   = DEPTH_W;
    localparam int BASE_W  = K_W + MAG_W;
    localparam int BASE_LO = BASE_W / 2;
    localparam int NUM_W   = BASE_W + WORD_BITS;
    localparam int DEN_W   = HH_W + CBRT_W;
    localparam int QUO_W   = WORD_BITS + 1;

    // Unit latencies in cycles
    localparam int SQRT_LAT = MAG_W;
    localparam int CBRT_LAT = CBRT_W;
    localparam int DIV_LAT  = QUO_W + 1;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_DRY     = 2'd1,
        ST_ZERO    = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    // Node data that rides beside the root units
    typedef struct packed {
        logic                 v;
        logic                 wet;
        logic                 hz;
        logic                 sx;
        logic                 sy;
        logic [WORD_BITS-1:0] ax;
        logic [WORD_BITS-1:0] ay;
        logic [WORD_BITS-1:0] rx;
        logic [WORD_BITS-1:0] ry;
    } t_side1;

    // Node data that rides beside the dividers
    typedef struct packed {
        logic                 v;
        logic                 wet;
        logic                 hz;
        logic                 sx;
        logic                 sy;
        logic [WORD_BITS-1:0] rx;
        logic [WORD_BITS-1:0] ry;
    } t_side2;

endpackage

>>> rtl/core/mft_dly.sv
module mft_dly #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_tap [DEPTH];

    // Shift the word down the line, clear all taps on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) r_tap[i] <= '0;
        end else begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) r_tap[i] <= r_tap[i-1];
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

>>> rtl/core/mft_sqrt.sv
module mft_sqrt #(
    parameter int IN_W  = 64,
    parameter int OUT_W = 32
) (
    input  logic             i_clk,
    input  logic [IN_W-1:0]  i_x,
    output logic [OUT_W-1:0] o_root
);

    localparam int AW = IN_W + 2;

    logic [IN_W-1:0]  r_x  [OUT_W];
    logic [OUT_W-1:0] r_c  [OUT_W];
    logic [AW-1:0]    r_c2 [OUT_W];

    // One result bit per stage, most significant first; keep c and c^2
    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        localparam int B = OUT_W - 1 - s;
        logic [IN_W-1:0]  x_in;
        logic [OUT_W-1:0] c_in;
        logic [AW-1:0]    c2_in;
        logic [AW-1:0]    trial;

        if (s == 0) begin : g_first
            assign x_in  = i_x;
            assign c_in  = '0;
            assign c2_in = '0;
        end else begin : g_next
            assign x_in  = r_x[s-1];
            assign c_in  = r_c[s-1];
            assign c2_in = r_c2[s-1];
        end

        // (c + 2^B)^2 = c^2 + c*2^(B+1) + 2^(2B)
        assign trial = c2_in + (AW'(c_in) << (B + 1)) + (AW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            r_x[s] <= x_in;
            if (trial <= AW'(x_in)) begin
                r_c[s]  <= c_in | (OUT_W'(1) << B);
                r_c2[s] <= trial;
            end else begin
                r_c[s]  <= c_in;
                r_c2[s] <= c2_in;
            end
        end
    end

    assign o_root = r_c[OUT_W-1];

endmodule

>>> rtl/core/mft_cbrt.sv
module mft_cbrt #(
    parameter int IN_W  = 63,
    parameter int OUT_W = 21
) (
    input  logic             i_clk,
    input  logic [IN_W-1:0]  i_x,
    output logic [OUT_W-1:0] o_root
);

    localparam int AW = 3 * OUT_W + 2;

    logic [IN_W-1:0]  r_x  [OUT_W];
    logic [OUT_W-1:0] r_c  [OUT_W];
    logic [AW-1:0]    r_c2 [OUT_W];
    logic [AW-1:0]    r_c3 [OUT_W];

    // One result bit per stage; keep c, c^2 and c^3 so each trial is adds only
    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        localparam int B = OUT_W - 1 - s;
        logic [IN_W-1:0]  x_in;
        logic [OUT_W-1:0] c_in;
        logic [AW-1:0]    c2_in;
        logic [AW-1:0]    c3_in;
        logic [AW-1:0]    c2x3;
        logic [AW-1:0]    cx3;
        logic [AW-1:0]    trial2;
        logic [AW-1:0]    trial3;

        if (s == 0) begin : g_first
            assign x_in  = i_x;
            assign c_in  = '0;
            assign c2_in = '0;
            assign c3_in = '0;
        end else begin : g_next
            assign x_in  = r_x[s-1];
            assign c_in  = r_c[s-1];
            assign c2_in = r_c2[s-1];
            assign c3_in = r_c3[s-1];
        end

        assign c2x3   = (c2_in << 1) + c2_in;
        assign cx3    = (AW'(c_in) << 1) + AW'(c_in);
        // (c + 2^B)^3 = c^3 + 3c^2*2^B + 3c*2^(2B) + 2^(3B)
        assign trial3 = c3_in + (c2x3 << B) + (cx3 << (2 * B)) + (AW'(1) << (3 * B));
        assign trial2 = c2_in + (AW'(c_in) << (B + 1)) + (AW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            r_x[s] <= x_in;
            if (trial3 <= AW'(x_in)) begin
                r_c[s]  <= c_in | (OUT_W'(1) << B);
                r_c2[s] <= trial2;
                r_c3[s] <= trial3;
            end else begin
                r_c[s]  <= c_in;
                r_c2[s] <= c2_in;
                r_c3[s] <= c3_in;
            end
        end
    end

    assign o_root = r_c[OUT_W-1];

endmodule

>>> rtl/core/mft_div.sv
module mft_div #(
    parameter int NUM_W = 88,
    parameter int DEN_W = 83,
    parameter int QUO_W = 33
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_ovf
);

    localparam int CW = DEN_W + QUO_W + 1;

    logic [NUM_W-1:0] r_rem [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0] r_q   [QUO_W+1];
    logic             r_ovf [QUO_W+1];

    // Flag a quotient that does not fit, then restore one bit per stage
    for (genvar s = 0; s <= QUO_W; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_ovf[0] <= CW'(i_num) >= (CW'(i_den) << QUO_W);
                r_rem[0] <= i_num;
                r_den[0] <= i_den;
                r_q[0]   <= '0;
            end
        end else begin : g_next
            localparam int B = QUO_W - s;
            logic [CW-1:0] shifted;
            logic [CW-1:0] diff;

            assign shifted = CW'(r_den[s-1]) << B;
            assign diff    = CW'(r_rem[s-1]) - shifted;

            always_ff @(posedge i_clk) begin
                r_ovf[s] <= r_ovf[s-1];
                r_den[s] <= r_den[s-1];
                if (CW'(r_rem[s-1]) >= shifted) begin
                    r_rem[s] <= diff[NUM_W-1:0];
                    r_q[s]   <= r_q[s-1] | (QUO_W'(1) << B);
                end else begin
                    r_rem[s] <= r_rem[s-1];
                    r_q[s]   <= r_q[s-1];
                end
            end
        end
    end

    assign o_quo = r_q[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule

>>> rtl/core/manning_friction_source_term.sv
// A node taken with start reaches o_valid via stages A-D, roots, dividers, output.
// Throughput: one node per cycle; busy stays low, start may be held every cycle.
// Depth is set by the 32-stage square root and the 34-stage quotient pipelines.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
module manning_friction_source_term (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mft_pkg::ADDR_W-1:0]          paddr,
    input  logic [mft_pkg::APB_W-1:0]           pwdata,
    output logic [mft_pkg::APB_W-1:0]           prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_wet,
    input  logic [mft_pkg::DEPTH_W-1:0]         i_depth,
    input  logic signed [mft_pkg::WORD_BITS-1:0] i_flux_x,
    input  logic signed [mft_pkg::WORD_BITS-1:0] i_flux_y,
    input  logic signed [mft_pkg::WORD_BITS-1:0] i_rhs_x_in,
    input  logic signed [mft_pkg::WORD_BITS-1:0] i_rhs_y_in,
    output logic                                o_valid,
    output logic signed [mft_pkg::WORD_BITS-1:0] o_rhs_x_out,
    output logic signed [mft_pkg::WORD_BITS-1:0] o_rhs_y_out,
    output logic [1:0]                          o_status
);

    localparam int W = mft_pkg::WORD_BITS;

    logic [mft_pkg::GRAV_W-1:0]  r_gravity;
    logic [mft_pkg::ROUGH_W-1:0] r_roughness;
    logic [mft_pkg::GN_W-1:0]    r_gn;
    logic [mft_pkg::K_W-1:0]     r_k;
    logic [mft_pkg::GNN_W-1:0]   gnn;
    logic                        cfg_wr;

    // Configuration port: writes complete in the access phase, no wait states
    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= mft_pkg::GRAVITY_RST;
            r_roughness <= mft_pkg::ROUGHNESS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[mft_pkg::ADDR_W-1])
                mft_pkg::REG_GRAVITY:   r_gravity   <= pwdata[mft_pkg::GRAV_W-1:0];
                mft_pkg::REG_ROUGHNESS: r_roughness <= pwdata[mft_pkg::ROUGH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[mft_pkg::ADDR_W-1])
            mft_pkg::REG_GRAVITY:   prdata = mft_pkg::APB_W'(r_gravity);
            mft_pkg::REG_ROUGHNESS: prdata = mft_pkg::APB_W'(r_roughness);
            default:                prdata = '0;
        endcase
    end

    // Friction coefficient k = g*n^2, refreshed every cycle from the registers
    assign gnn = mft_pkg::GNN_W'(r_gn) * mft_pkg::GNN_W'(r_roughness);

    always_ff @(posedge i_clk) begin
        r_gn <= mft_pkg::GN_W'(r_gravity) * mft_pkg::GN_W'(r_roughness);
        r_k  <= gnn[mft_pkg::GNN_W-1 -: mft_pkg::K_W];
    end

    // Stage A: capture the node
    logic                          r_a_v;
    logic                          r_a_wet;
    logic [mft_pkg::DEPTH_W-1:0]   r_a_h;
    logic [W-1:0]                  r_a_qx;
    logic [W-1:0]                  r_a_qy;
    logic [W-1:0]                  r_a_rx;
    logic [W-1:0]                  r_a_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start && !busy;
        end
        r_a_wet <= i_wet;
        r_a_h   <= i_depth;
        r_a_qx  <= i_flux_x;
        r_a_qy  <= i_flux_y;
        r_a_rx  <= i_rhs_x_in;
        r_a_ry  <= i_rhs_y_in;
    end

    // Stage B: momentum magnitudes and special-case flags
    mft_pkg::t_side1             n_b_sb;
    mft_pkg::t_side1             r_b_sb;
    logic [mft_pkg::DEPTH_W-1:0] r_b_h;

    always_comb begin
        n_b_sb.v   = r_a_v;
        n_b_sb.wet = r_a_wet;
        n_b_sb.hz  = (r_a_h == '0);
        n_b_sb.sx  = r_a_qx[W-1];
        n_b_sb.sy  = r_a_qy[W-1];
        n_b_sb.ax  = r_a_qx[W-1] ? (~r_a_qx + W'(1)) : r_a_qx;
        n_b_sb.ay  = r_a_qy[W-1] ? (~r_a_qy + W'(1)) : r_a_qy;
        n_b_sb.rx  = r_a_rx;
        n_b_sb.ry  = r_a_ry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_sb.v <= 1'b0;
        end else begin
            r_b_sb <= n_b_sb;
        end
        r_b_h <= r_a_h;
    end

    // Stage C: squares of the momenta and of the depth
    mft_pkg::t_side1             r_c_sb;
    logic [mft_pkg::SQ_W-1:0]    r_c_sqx;
    logic [mft_pkg::SQ_W-1:0]    r_c_sqy;
    logic [mft_pkg::HH_W-1:0]    r_c_hh;
    logic [mft_pkg::DEPTH_W-1:0] r_c_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_sb.v <= 1'b0;
        end else begin
            r_c_sb <= r_b_sb;
        end
        r_c_sqx <= mft_pkg::SQ_W'(r_b_sb.ax) * mft_pkg::SQ_W'(r_b_sb.ax);
        r_c_sqy <= mft_pkg::SQ_W'(r_b_sb.ay) * mft_pkg::SQ_W'(r_b_sb.ay);
        r_c_hh  <= mft_pkg::HH_W'(r_b_h) * mft_pkg::HH_W'(r_b_h);
        r_c_h   <= r_b_h;
    end

    // Stage D: sum of squares and scaled depth for the two root units
    mft_pkg::t_side1          r_d_sb;
    logic [mft_pkg::SQ_W-1:0] r_d_sq;
    logic [mft_pkg::HS_W-1:0] r_d_hs;
    logic [mft_pkg::HH_W-1:0] r_d_hh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_sb.v <= 1'b0;
        end else begin
            r_d_sb <= r_c_sb;
        end
        r_d_sq <= r_c_sqx + r_c_sqy;
        r_d_hs <= {r_c_h, {(2 * mft_pkg::FRAC_BITS){1'b0}}};
        r_d_hh <= r_c_hh;
    end

    // Root units
    logic [mft_pkg::MAG_W-1:0]  mag;
    logic [mft_pkg::CBRT_W-1:0] croot;

    mft_sqrt #(
        .IN_W  (mft_pkg::SQ_W),
        .OUT_W (mft_pkg::MAG_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_x    (r_d_sq),
        .o_root (mag)
    );

    mft_cbrt #(
        .IN_W  (mft_pkg::HS_W),
        .OUT_W (mft_pkg::CBRT_W)
    ) u_cbrt (
        .i_clk  (i_clk),
        .i_x    (r_d_hs),
        .o_root (croot)
    );

    // Carry node data past the square root
    mft_pkg::t_side1 sb1;

    mft_dly #(
        .W     ($bits(mft_pkg::t_side1)),
        .DEPTH (mft_pkg::SQRT_LAT + 1)
    ) u_dly_sb1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_d_sb),
        .o_d     (sb1)
    );

    // Numerator: k * |q| * |q_vec|, wide product split in two halves
    localparam int PL_W = mft_pkg::BASE_LO + W;
    localparam int PH_W = mft_pkg::BASE_W - mft_pkg::BASE_LO + W;

    logic [mft_pkg::BASE_W-1:0] r_base;
    logic [PL_W-1:0]            r_px_lo;
    logic [PH_W-1:0]            r_px_hi;
    logic [PL_W-1:0]            r_py_lo;
    logic [PH_W-1:0]            r_py_hi;
    logic [mft_pkg::NUM_W-1:0]  r_px;
    logic [mft_pkg::NUM_W-1:0]  r_py;

    always_ff @(posedge i_clk) begin
        r_base  <= mft_pkg::BASE_W'(r_k) * mft_pkg::BASE_W'(mag);
        r_px_lo <= PL_W'(r_base[mft_pkg::BASE_LO-1:0]) * PL_W'(sb1.ax);
        r_px_hi <= PH_W'(r_base[mft_pkg::BASE_W-1:mft_pkg::BASE_LO]) * PH_W'(sb1.ax);
        r_py_lo <= PL_W'(r_base[mft_pkg::BASE_LO-1:0]) * PL_W'(sb1.ay);
        r_py_hi <= PH_W'(r_base[mft_pkg::BASE_W-1:mft_pkg::BASE_LO]) * PH_W'(sb1.ay);
        r_px    <= mft_pkg::NUM_W'(r_px_lo)
                 + (mft_pkg::NUM_W'(r_px_hi) << mft_pkg::BASE_LO);
        r_py    <= mft_pkg::NUM_W'(r_py_lo)
                 + (mft_pkg::NUM_W'(r_py_hi) << mft_pkg::BASE_LO);
    end

    // Narrow node data for the quotient pipelines
    mft_pkg::t_side2 n_sb2;
    mft_pkg::t_side2 sb2;

    always_comb begin
        n_sb2.v   = sb1.v;
        n_sb2.wet = sb1.wet;
        n_sb2.hz  = sb1.hz;
        n_sb2.sx  = sb1.sx;
        n_sb2.sy  = sb1.sy;
        n_sb2.rx  = sb1.rx;
        n_sb2.ry  = sb1.ry;
    end

    mft_dly #(
        .W     ($bits(mft_pkg::t_side2)),
        .DEPTH (mft_pkg::DIV_LAT + 2)
    ) u_dly_sb2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (n_sb2),
        .o_d     (sb2)
    );

    // Denominator: h^2 * cbrt(h), aligned to the numerator
    localparam int DL_W = mft_pkg::HH_LO + mft_pkg::CBRT_W;
    localparam int DH_W = mft_pkg::HH_W - mft_pkg::HH_LO + mft_pkg::CBRT_W;

    logic [mft_pkg::HH_W-1:0]  hh_d;
    logic [DL_W-1:0]           r_dn_lo;
    logic [DH_W-1:0]           r_dn_hi;
    logic [mft_pkg::DEN_W-1:0] r_den;
    logic [mft_pkg::DEN_W-1:0] den_d;

    mft_dly #(
        .W     (mft_pkg::HH_W),
        .DEPTH (mft_pkg::CBRT_LAT)
    ) u_dly_hh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_d_hh),
        .o_d     (hh_d)
    );

    always_ff @(posedge i_clk) begin
        r_dn_lo <= DL_W'(hh_d[mft_pkg::HH_LO-1:0]) * DL_W'(croot);
        r_dn_hi <= DH_W'(hh_d[mft_pkg::HH_W-1:mft_pkg::HH_LO]) * DH_W'(croot);
        r_den   <= mft_pkg::DEN_W'(r_dn_lo)
                 + (mft_pkg::DEN_W'(r_dn_hi) << mft_pkg::HH_LO);
    end

    mft_dly #(
        .W     (mft_pkg::DEN_W),
        .DEPTH (mft_pkg::SQRT_LAT + 3 - (mft_pkg::CBRT_LAT + 2))
    ) u_dly_den (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_den),
        .o_d     (den_d)
    );

    // Quotient pipelines, one per direction
    logic [mft_pkg::QUO_W-1:0] quo_x;
    logic [mft_pkg::QUO_W-1:0] quo_y;
    logic                      ovf_x;
    logic                      ovf_y;

    mft_div #(
        .NUM_W (mft_pkg::NUM_W),
        .DEN_W (mft_pkg::DEN_W),
        .QUO_W (mft_pkg::QUO_W)
    ) u_div_x (
        .i_clk (i_clk),
        .i_num (r_px),
        .i_den (den_d),
        .o_quo (quo_x),
        .o_ovf (ovf_x)
    );

    mft_div #(
        .NUM_W (mft_pkg::NUM_W),
        .DEN_W (mft_pkg::DEN_W),
        .QUO_W (mft_pkg::QUO_W)
    ) u_div_y (
        .i_clk (i_clk),
        .i_num (r_py),
        .i_den (den_d),
        .o_quo (quo_y),
        .o_ovf (ovf_y)
    );

    // Clamp the term to 2^W, apply it against the sign of q, saturate to a word
    function automatic logic [W:0] apply_term(
        input logic [W-1:0]                rhs,
        input logic                        neg,
        input logic [mft_pkg::QUO_W-1:0]   quo,
        input logic                        ovf
    );
        logic [mft_pkg::QUO_W-1:0] lim;
        logic [mft_pkg::QUO_W-1:0] tmag;
        logic signed [W+1:0]       srhs;
        logic signed [W+1:0]       smag;
        logic signed [W+1:0]       sum;
        logic signed [W+1:0]       smax;
        logic signed [W+1:0]       smin;
        logic [W:0]                res;
        lim  = mft_pkg::QUO_W'(1) << W;
        tmag = (ovf || quo > lim) ? lim : quo;
        srhs = $signed({{2{rhs[W-1]}}, rhs});
        smag = $signed({1'b0, tmag});
        smax = $signed({3'b000, {(W-1){1'b1}}});
        smin = $signed({3'b111, {(W-1){1'b0}}});
        sum  = neg ? (srhs + smag) : (srhs - smag);
        if (sum > smax) begin
            res = {1'b1, smax[W-1:0]};
        end else if (sum < smin) begin
            res = {1'b1, smin[W-1:0]};
        end else begin
            res = {1'b0, sum[W-1:0]};
        end
        return res;
    endfunction

    // Output stage: pick pass-through or friction result and register it
    logic [W:0]       app_x;
    logic [W:0]       app_y;
    logic             r_out_v;
    logic [W-1:0]     r_out_rx;
    logic [W-1:0]     r_out_ry;
    mft_pkg::t_status r_out_st;

    assign app_x = apply_term(sb2.rx, sb2.sx, quo_x, ovf_x);
    assign app_y = apply_term(sb2.ry, sb2.sy, quo_y, ovf_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= sb2.v;
        end
        if (!sb2.wet) begin
            r_out_rx <= sb2.rx;
            r_out_ry <= sb2.ry;
            r_out_st <= mft_pkg::ST_DRY;
        end else if (sb2.hz) begin
            r_out_rx <= sb2.rx;
            r_out_ry <= sb2.ry;
            r_out_st <= mft_pkg::ST_ZERO;
        end else begin
            r_out_rx <= app_x[W-1:0];
            r_out_ry <= app_y[W-1:0];
            r_out_st <= (app_x[W] || app_y[W]) ? mft_pkg::ST_SAT : mft_pkg::ST_APPLIED;
        end
    end

    assign o_valid     = r_out_v;
    assign o_rhs_x_out = r_out_rx;
    assign o_rhs_y_out = r_out_ry;
    assign o_status    = r_out_st;

endmodule

>>> tb/tb_manning_friction_source_term.sv
module tb_manning_friction_source_term;
    import mft_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 80;

    typedef struct {
        logic                        wet;
        logic [DEPTH_W-1:0]          depth;
        logic signed [WORD_BITS-1:0] flux_x;
        logic signed [WORD_BITS-1:0] flux_y;
        logic signed [WORD_BITS-1:0] rhs_x;
        logic signed [WORD_BITS-1:0] rhs_y;
    } t_node;

    typedef struct {
        logic signed [WORD_BITS-1:0] rhs_x;
        logic signed [WORD_BITS-1:0] rhs_y;
        t_status                     status;
    } t_friction;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel, penable, pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [APB_W-1:0]            pwdata;
    logic [APB_W-1:0]            prdata;
    logic                        pready;
    logic                        start;
    logic                        busy;
    logic                        i_wet;
    logic [DEPTH_W-1:0]          i_depth;
    logic signed [WORD_BITS-1:0] i_flux_x, i_flux_y, i_rhs_x_in, i_rhs_y_in;
    logic                        o_valid;
    logic signed [WORD_BITS-1:0] o_rhs_x_out, o_rhs_y_out;
    logic [1:0]                  o_status;

    // Shadow copy of the configuration registers
    logic [GRAV_W-1:0]  grav_cfg;
    logic [ROUGH_W-1:0] rough_cfg;

    t_friction friction_q[$];
    int        fail_count;
    int        cycle_count;
    bit        burst_mode;

    manning_friction_source_term uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Integer square root with a result of up to 48 bits
    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  y;
        logic [127:0] yy;
        r = '0;
        for (int b = 47; b >= 0; b--) begin
            y  = r | (64'd1 << b);
            yy = {64'd0, y} * {64'd0, y};
            if (yy <= x) r = y;
        end
        return r;
    endfunction

    // Integer cube root
    function automatic logic [63:0] icbrt(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  y;
        logic [127:0] yyy;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            y   = r | (64'd1 << b);
            yyy = {64'd0, y} * {64'd0, y} * {64'd0, y};
            if (yyy <= x) r = y;
        end
        return r;
    endfunction

    // Subtract the signed friction magnitude and clamp to the word
    function automatic logic signed [WORD_BITS-1:0] reduce_rhs(
            logic signed [WORD_BITS-1:0] rhs, logic neg, logic [127:0] t, inout bit sat);
        logic [127:0] lim;
        longint       mag;
        longint       res;
        lim = 128'd1 << WORD_BITS;
        mag = (t > lim) ? longint'(lim) : longint'(t);
        res = neg ? longint'(rhs) + mag : longint'(rhs) - mag;
        if (res > 64'sh7FFFFFFF) begin
            res = 64'sh7FFFFFFF;
            sat = 1'b1;
        end
        if (res < -64'sh80000000) begin
            res = -64'sh80000000;
            sat = 1'b1;
        end
        return res[WORD_BITS-1:0];
    endfunction

    function automatic t_friction manning_friction(t_node n);
        t_friction    r;
        logic [127:0] ax, ay, h, k, m, c, base, tx, ty;
        bit           sat;
        sat = 1'b0;
        r.rhs_x = n.rhs_x;
        r.rhs_y = n.rhs_y;
        if (!n.wet) begin
            r.status = ST_DRY;
            return r;
        end
        if (n.depth == '0) begin
            r.status = ST_ZERO;
            return r;
        end
        ax   = n.flux_x[WORD_BITS-1] ? 128'(-longint'(n.flux_x)) : 128'(longint'(n.flux_x));
        ay   = n.flux_y[WORD_BITS-1] ? 128'(-longint'(n.flux_y)) : 128'(longint'(n.flux_y));
        h    = 128'(n.depth);
        m    = isqrt(ax * ax + ay * ay);
        c    = icbrt(h << (2 * FRAC_BITS));
        k    = (128'(grav_cfg) * 128'(rough_cfg) * 128'(rough_cfg)) >> (GR_FRAC - FRAC_BITS);
        base = k * m;
        tx   = base * ax / h / h / c;
        ty   = base * ay / h / h / c;
        r.rhs_x  = reduce_rhs(n.rhs_x, n.flux_x[WORD_BITS-1], tx, sat);
        r.rhs_y  = reduce_rhs(n.rhs_y, n.flux_y[WORD_BITS-1], ty, sat);
        r.status = sat ? ST_SAT : ST_APPLIED;
        return r;
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_friction e;
        if (i_rst_n && o_valid) begin
            if (friction_q.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h st=%0d", $time,
                         o_rhs_x_out, o_rhs_y_out, o_status);
                fail_count++;
            end else begin
                e = friction_q.pop_front();
                if (o_rhs_x_out !== e.rhs_x) begin
                    $display("%0t: rhs_x expected %h actual %h", $time, e.rhs_x, o_rhs_x_out);
                    fail_count++;
                end
                if (o_rhs_y_out !== e.rhs_y) begin
                    $display("%0t: rhs_y expected %h actual %h", $time, e.rhs_y, o_rhs_y_out);
                    fail_count++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    // Present one node after a random gap, none in burst mode, and hold it until transfer
    task automatic send_node(t_node n);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_wet      <= n.wet;
        i_depth    <= n.depth;
        i_flux_x   <= n.flux_x;
        i_flux_y   <= n.flux_y;
        i_rhs_x_in <= n.rhs_x;
        i_rhs_y_in <= n.rhs_y;
        do @(posedge i_clk); while (busy);
        friction_q.push_back(manning_friction(n));
    endtask

    // Drop start and wait out all results
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (friction_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GRAVITY) grav_cfg = value[GRAV_W-1:0];
        else rough_cfg = value[ROUGH_W-1:0];
    endtask

    task automatic set_config(logic [APB_W-1:0] g, logic [APB_W-1:0] n);
        write_reg(REG_GRAVITY, g);
        write_reg(REG_ROUGHNESS, n);
    endtask

    function automatic t_node make_node(logic w, logic [DEPTH_W-1:0] d, int fx, int fy,
                                        int rx, int ry);
        t_node n;
        n.wet = w; n.depth = d; n.flux_x = fx; n.flux_y = fy; n.rhs_x = rx; n.rhs_y = ry;
        return n;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'($signed($urandom_range(0, 131071)) - 65536);
            3:       return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_node rand_node();
        t_node n;
        n.wet = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0:       n.depth = '0;
            1:       n.depth = DEPTH_W'($urandom_range(1, 16));
            2:       n.depth = {DEPTH_W{1'b1}};
            3, 4:    n.depth = DEPTH_W'($urandom_range(1, 65535));
            5, 6:    n.depth = DEPTH_W'($urandom_range(65536, 2 ** 22));
            default: n.depth = DEPTH_W'($urandom);
        endcase
        n.flux_x = rand_word();
        n.flux_y = rand_word();
        n.rhs_x  = rand_word();
        n.rhs_y  = rand_word();
        return n;
    endfunction

    // Dry, zero depth, zero momentum, field extremes and saturation, then full and zero register settings
    task automatic test_directed;
        burst_mode = 1'b0;
        send_node(make_node(1'b0, 31'd65536, 32'h00010000, -32'sd65536, 32'h12345678, -32'sd5));
        send_node(make_node(1'b0, '1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        send_node(make_node(1'b1, '0, 32'h00010000, 32'h00020000, 32'h11111111, 32'h22222222));
        send_node(make_node(1'b1, '0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        send_node(make_node(1'b1, 31'd65536, 0, 0, 32'h00001000, -32'sd4096));
        send_node(make_node(1'b1, 31'd65536, 32'h00010000, 32'h00010000, 0, 0));
        send_node(make_node(1'b1, 31'd65536, -32'sd65536, -32'sd131072, 0, 0));
        send_node(make_node(1'b1, 31'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0));
        send_node(make_node(1'b1, 31'd1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0));
        send_node(make_node(1'b1, '1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        send_node(make_node(1'b1, 31'd6554, 32'h00050000, 32'hFFFD0000, 32'h00002000, 32'h1));
        send_node(make_node(1'b1, 31'd16, 32'h00100000, 0, 32'h80000001, 32'h7FFFFFFE));
        drain();
        set_config(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_node(make_node(1'b1, 31'd1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
        send_node(make_node(1'b1, 31'd65536, 32'h00010000, 32'h00010000, 32'h7FFFFFFF, 0));
        send_node(make_node(1'b1, '1, 32'h00000001, 32'hFFFFFFFF, 0, 0));
        drain();
        set_config(32'd0, 32'd0);
        send_node(make_node(1'b1, 31'd1, 32'h7FFFFFFF, 32'h80000000, 32'h5, 32'h6));
        drain();
    endtask

    // Random nodes over one register setting, with bursts of back-to-back transfers
    task automatic test_random(logic [APB_W-1:0] g, logic [APB_W-1:0] n, int count);
        set_config(g, n);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            send_node(rand_node());
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0; i_wet = 1'b0; i_depth = '0;
        i_flux_x = '0; i_flux_y = '0; i_rhs_x_in = '0; i_rhs_y_in = '0;
        grav_cfg = GRAVITY_RST;
        rough_cfg = ROUGHNESS_RST;
        burst_mode = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(32'(GRAVITY_RST), 32'(ROUGHNESS_RST), 400);
        test_random(32'h00FFFFFF, 32'h0000FFFF, 300);
        test_random(32'd0, 32'h0000FFFF, 150);
        test_random(32'h00FFFFFF, 32'd0, 150);
        test_random($urandom, $urandom, 300);
        test_random(32'h00FFFFFF, 32'h00008000, 250);
        test_random($urandom, $urandom, 275);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
